// File: src/pal_pkg.sv
// Shared types and constants for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int DEPTH   = 64;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 6;
    localparam int CAP_W   = 7;
    localparam int OUTL_W  = 7;
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (LEN_W > CAP_W) ? LEN_W : CAP_W;
    localparam int GRP     = 8;
    localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
    localparam int CAP_RST = 64;

    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_RED
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic upd;    // apply cmd to the store
        logic rd_en;  // drive selected entry onto read bus
        t_cmd cmd;
        t_len pos;    // insert position already clamped
    } t_cell_ctl;

endpackage

// File: src/pal_cell.sv
// One storage cell of the list: holds one entry, shifts with its neighbors.
`timescale 1ns / 1ps

module pal_cell
    import pal_pkg::*;
(
    input  logic      i_clk,
    input  t_len      i_idx,
    input  t_cell_ctl i_ctl,
    input  t_word     i_left,
    input  t_word     i_right,
    input  t_word     i_item,
    output t_word     o_word,
    output t_word     o_rd
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.upd) begin
            case (i_ctl.cmd)
                CMD_INSERT: begin
                    if (i_idx > i_ctl.pos) begin
                        n_word = i_left;
                    end else if (i_idx == i_ctl.pos) begin
                        n_word = i_item;
                    end
                end
                CMD_DELETE: begin
                    if (i_idx >= i_ctl.pos) begin
                        n_word = i_right;
                    end
                end
                CMD_CLEAR: n_word = '0;
                default:   n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = (i_ctl.rd_en && (i_idx == i_ctl.pos)) ? r_word : '0;

endmodule

// File: src/positional_array_list_top.sv
// Top level of the positional array list: command decode, cell chain, read reduction.
`timescale 1ns / 1ps

// Positional array list. Holds up to DEPTH nonzero 32-bit words in order, in
// a row of cells that each keep one entry and pass it to a neighbor, so an
// insert or delete shifts the whole tail at once. Each accepted command
// gives exactly one result beat with status, the removed or read word, and the
// list length after the command. In S_IDLE the command is decoded, every cell
// is updated and per-group partial reads (groups of eight cells) are registered;
// in S_RED the group partials are ORed into the result register once the output
// side can take it. One command is worked on at a
// time; the next may enter while a finished result still waits on o_valid.
// Out-of-range deletes/gets return status 3, refused commands change nothing.
// Capacity is written on the config channel, which is always ready; write it
// only while no command is in flight. No clearing pass is needed after reset:
// entries beyond the length are never returned.
module positional_array_list_top
    import pal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [POS_W-1:0]   i_position,
    input  logic [WORD_W-1:0]  i_item_value,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [WORD_W-1:0]  o_read_value,
    output logic [OUTL_W-1:0]  o_list_length_out,
    // capacity write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_capacity_in_use
);

    // ---------------- state ----------------
    t_state          r_state;
    t_state          n_state;
    t_len            r_len;
    t_len            n_len;
    logic [CAP_W-1:0] r_cap;
    t_status         r_pend_status;
    t_status         n_status;
    t_word           r_part [NGRP];
    logic            r_out_valid;
    t_status         r_out_status;
    t_word           r_out_value;
    t_len            r_out_len;

    logic            w_accept;
    logic            w_load_out;
    t_cmd            w_cmd;
    t_cell_ctl       w_ctl;
    t_word           w_word [DEPTH];
    t_word           w_rd   [DEPTH];
    t_word           w_part [NGRP];
    t_word           w_red;

    // comparisons in a width that holds length, capacity and position
    logic [CMP_W-1:0] w_len_c;
    logic [CMP_W-1:0] w_cap_c;
    logic [CMP_W-1:0] w_pos_c;
    logic [CMP_W-1:0] w_dep_c;
    t_len            w_pos_ins;

    assign w_cmd    = t_cmd'(i_cmd);
    assign w_accept = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign w_len_c = CMP_W'(r_len);
    assign w_cap_c = CMP_W'(r_cap);
    assign w_pos_c = CMP_W'(i_position);
    assign w_dep_c = CMP_W'(DEPTH);

    // ---------------- command decode ----------------
    always_comb begin
        n_status  = ST_OK;
        n_len     = r_len;
        w_pos_ins = (w_pos_c > w_len_c) ? r_len : t_len'(i_position);
        w_ctl.cmd = w_cmd;
        w_ctl.pos = t_len'(i_position);
        case (w_cmd)
            CMD_INSERT: begin
                w_ctl.pos = w_pos_ins;
                if (i_item_value == '0) begin
                    n_status = ST_NULL;
                end else if (w_len_c >= w_cap_c || w_len_c >= w_dep_c) begin
                    n_status = ST_FULL;
                end else begin
                    n_len = r_len + t_len'(1);
                end
            end
            CMD_DELETE: begin
                if (w_pos_c >= w_len_c) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_len = r_len - t_len'(1);
                end
            end
            CMD_GET: begin
                if (w_pos_c >= w_len_c) begin
                    n_status = ST_BADPOS;
                end
            end
            default: n_len = '0;
        endcase
        w_ctl.upd   = w_accept && (n_status == ST_OK);
        w_ctl.rd_en = w_accept && (n_status == ST_OK) &&
                      (w_cmd == CMD_DELETE || w_cmd == CMD_GET);
    end

    // ---------------- cell chain ----------------
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[gi+1];
        end
        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (t_len'(gi)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_item  (i_item_value),
            .o_word  (w_word[gi]),
            .o_rd    (w_rd[gi])
        );
    end

    // ---------------- read reduction ----------------
    // first level: OR within each group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_part[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < DEPTH) begin
                    w_part[g] = w_part[g] | w_rd[g * GRP + k];
                end
            end
        end
    end

    // second level: OR across registered group partials
    always_comb begin
        w_red = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_red = w_red | r_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int g = 0; g < NGRP; g++) begin
                r_part[g] <= w_part[g];
            end
            r_pend_status <= n_status;
        end
    end

    // ---------------- control FSM ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_RED;
            S_RED:   if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = (r_state == S_IDLE);
        w_load_out = (r_state == S_RED) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cap       <= CAP_W'(CAP_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_len <= n_len;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_capacity_in_use;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; length is final once the command leaves S_IDLE
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_pend_status;
            r_out_value  <= w_red;
            r_out_len    <= r_len;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_read_value      = r_out_value;
    assign o_list_length_out = OUTL_W'(r_out_len);

endmodule
